@@ hdl/slc_pkg.sv @@
// Shared types, constants and helper functions of the triangle slicing block.
package slc_pkg;

   localparam int DIV_STEPS   = 33;
   localparam int SCALE_LAT   = DIV_STEPS + 3;
   localparam int CSR_ADDR_W  = 3;
   localparam logic [15:0] THRESHOLD_RESET = 16'd66;
   localparam logic REG_THRESHOLD = 1'b0;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } vtx_type;

   typedef struct packed {
      logic [31:0]       layer_y;
      logic [11:0]       layer_index;
      vtx_type [2:0]     v;
   } tri_type;

   typedef struct packed {
      logic [31:0] base_x;
      logic [31:0] base_z;
      logic [31:0] out_y;
      logic [32:0] n;
      logic [32:0] dx;
      logic [32:0] dz;
      logic [32:0] dy;
   } slot_type;

   typedef struct packed {
      logic [11:0] layer;
      slot_type    p;
      slot_type    q;
   } job_type;

   function automatic logic [32:0] diff33(logic [31:0] u, logic [31:0] w);
      return {u[31], u} - {w[31], w};
   endfunction

   function automatic logic [32:0] abs33(logic [32:0] a);
      return a[32] ? 33'(-a) : a;
   endfunction

   function automatic logic crosses(vtx_type u, vtx_type w, logic [31:0] ly);
      logic same;
      logic above;
      logic below;
      same  = (u == w);
      above = ($signed(u.y) > $signed(ly)) && ($signed(w.y) > $signed(ly));
      below = ($signed(u.y) < $signed(ly)) && ($signed(w.y) < $signed(ly));
      return !same && !above && !below && (u.y != w.y);
   endfunction

   function automatic slot_type edge_slot(vtx_type u, vtx_type w, logic [31:0] ly);
      slot_type s;
      s.base_x = w.x;
      s.base_z = w.z;
      s.out_y  = ly;
      s.n      = diff33(ly, w.y);
      s.dx     = diff33(u.x, w.x);
      s.dz     = diff33(u.z, w.z);
      s.dy     = diff33(u.y, w.y);
      return s;
   endfunction

   function automatic slot_type vertex_slot(vtx_type v);
      slot_type s;
      s.base_x = v.x;
      s.base_z = v.z;
      s.out_y  = v.y;
      s.n      = '0;
      s.dx     = '0;
      s.dz     = '0;
      s.dy     = 33'd1;
      return s;
   endfunction

endpackage

@@ hdl/triangle_layer_slice_segment.sv @@
// Top level of the triangle slicer: cuts one triangle with a horizontal layer.
//
// A triangle transaction is accepted at a rising clock edge where start is high
// and busy is low. It carries the layer height, the layer index and the three
// vertices a, b and c, all coordinates in signed Q16.16.
// Each accepted triangle gives zero or one segment. A segment appears on the
// rsp_ ports for exactly one cycle, marked by rsp_valid; triangles that give
// no segment leave no trace.
// One triangle may be accepted every cycle. The path runs through the
// classifier register, the queue and the endpoint interpolation: a 32x32
// partial-product multiply, its sum, then a 33-stage restoring divider with
// one quotient bit per stage and a final add.
// The receiver cannot stall, so busy stays low; the queue between the
// classifier and the arithmetic never holds more than one transaction.
// The APB-style csr_ port holds on_layer_threshold at byte address 0.
// A synchronous reset empties the pipeline and sets the threshold to 66.
module triangle_layer_slice_segment #(
   parameter int MAX_LAYERS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [31:0]                    req_layer_y,
   input  logic [11:0]                    req_layer_index,
   input  logic [31:0]                    req_a_x,
   input  logic [31:0]                    req_a_y,
   input  logic [31:0]                    req_a_z,
   input  logic [31:0]                    req_b_x,
   input  logic [31:0]                    req_b_y,
   input  logic [31:0]                    req_b_z,
   input  logic [31:0]                    req_c_x,
   input  logic [31:0]                    req_c_y,
   input  logic [31:0]                    req_c_z,
   output logic                           rsp_valid,
   output logic [31:0]                    rsp_p_x,
   output logic [31:0]                    rsp_p_y,
   output logic [31:0]                    rsp_p_z,
   output logic [31:0]                    rsp_q_x,
   output logic [31:0]                    rsp_q_y,
   output logic [31:0]                    rsp_q_z,
   output logic [11:0]                    rsp_segment_layer,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [slc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   localparam int TOTAL_LAT = slc_pkg::SCALE_LAT + 2;

   // Configuration register; the user must write it only while the block is idle; the block does not enforce this.
   logic [15:0] threshold_ff;
   logic        csr_hit;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == slc_pkg::REG_THRESHOLD);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {16'd0, threshold_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= slc_pkg::THRESHOLD_RESET;
      end else if (csr_write && csr_hit) begin
         threshold_ff <= csr_pwdata[15:0];
      end
   end

   // Gather the request into one triangle record.
   slc_pkg::tri_type tri_req;
   logic             accept;
   logic             layer_ok;

   assign tri_req.layer_y     = req_layer_y;
   assign tri_req.layer_index = req_layer_index;
   assign tri_req.v[0]        = '{x: req_a_x, y: req_a_y, z: req_a_z};
   assign tri_req.v[1]        = '{x: req_b_x, y: req_b_y, z: req_b_z};
   assign tri_req.v[2]        = '{x: req_c_x, y: req_c_y, z: req_c_z};
   assign accept              = start && !busy;
   // Layers past the configured count are dropped without a segment.
   assign layer_ok            = 32'(req_layer_index) < 32'(MAX_LAYERS);

   // The classifier decides whether a segment exists and which two points
   // form it, so that the back end only ever does interpolation.
   logic             push;
   slc_pkg::job_type push_job;

   slc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .tri_in    (tri_req),
      .layer_ok  (layer_ok),
      .threshold (threshold_ff),
      .push      (push),
      .job       (push_job)
   );

   logic             head_valid;
   slc_pkg::job_type head_job;
   logic             queue_full;

   slc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (queue_full)
   );

   assign busy = queue_full;

   // Vertex endpoints travel as crossings with a zero offset, so every
   // endpoint takes the same path and the latency never varies.
   slc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .out_valid (rsp_valid),
      .p_x       (rsp_p_x),
      .p_y       (rsp_p_y),
      .p_z       (rsp_p_z),
      .q_x       (rsp_q_x),
      .q_y       (rsp_q_y),
      .q_z       (rsp_q_z),
      .layer     (rsp_segment_layer)
   );

`ifndef SYNTHESIS
   // The queue is drained every cycle, so it can never fill up.
   a_queue_never_full: assert property (@(posedge clock) disable iff (reset)
      !queue_full)
      else $error("slice queue filled up");

   // Every segment stems from a transaction accepted a fixed time earlier.
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, TOTAL_LAT))
      else $error("segment without matching triangle transaction");
`endif

endmodule

@@ hdl/slc_front.sv @@
// Front end: registers a triangle and classifies how the layer cuts it.
module slc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  slc_pkg::tri_type   tri_in,
   input  logic               layer_ok,
   input  logic [15:0]        threshold,
   output logic               push,
   output slc_pkg::job_type   job
);

   logic             valid_ff;
   logic             ok_ff;
   slc_pkg::tri_type tri_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tri_ff <= tri_in;
         ok_ff  <= layer_ok;
      end
   end

   logic [2:0]        gt, lt, eq, on;
   logic [2:0]        cr;
   logic              emit;
   slc_pkg::slot_type e0, e1, e2;
   slc_pkg::slot_type vs0, vs1, vs2;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         gt[i] = $signed(tri_ff.v[i].y) > $signed(tri_ff.layer_y);
         lt[i] = $signed(tri_ff.v[i].y) < $signed(tri_ff.layer_y);
         eq[i] = tri_ff.v[i].y == tri_ff.layer_y;
         on[i] = slc_pkg::abs33(slc_pkg::diff33(tri_ff.v[i].y, tri_ff.layer_y))
                 < {17'd0, threshold};
      end
      cr[0] = slc_pkg::crosses(tri_ff.v[0], tri_ff.v[1], tri_ff.layer_y);
      cr[1] = slc_pkg::crosses(tri_ff.v[0], tri_ff.v[2], tri_ff.layer_y);
      cr[2] = slc_pkg::crosses(tri_ff.v[1], tri_ff.v[2], tri_ff.layer_y);
      e0  = slc_pkg::edge_slot(tri_ff.v[0], tri_ff.v[1], tri_ff.layer_y);
      e1  = slc_pkg::edge_slot(tri_ff.v[0], tri_ff.v[2], tri_ff.layer_y);
      e2  = slc_pkg::edge_slot(tri_ff.v[1], tri_ff.v[2], tri_ff.layer_y);
      vs0 = slc_pkg::vertex_slot(tri_ff.v[0]);
      vs1 = slc_pkg::vertex_slot(tri_ff.v[1]);
      vs2 = slc_pkg::vertex_slot(tri_ff.v[2]);

      job.layer = tri_ff.layer_index;
      job.p     = e0;
      job.q     = e1;
      emit      = 1'b0;

      if (!ok_ff || (&gt) || (&lt)) begin
         emit = 1'b0;
      end else if (!(|eq)) begin
         // Strict cut: keep the first two crossing edges in edge order.
         emit = ($countones(cr) == 2);
         if (!cr[0]) begin
            job.p = e1;
            job.q = e2;
         end else if (!cr[1]) begin
            job.q = e2;
         end
      end else begin
         unique case (on)
            3'b001: begin
               job.p = vs0;
               job.q = e2;
               emit  = cr[2];
            end
            3'b010: begin
               job.p = vs1;
               job.q = e1;
               emit  = cr[1];
            end
            3'b100: begin
               job.p = vs2;
               job.q = e0;
               emit  = cr[0];
            end
            3'b011: begin
               job.p = vs0;
               job.q = vs1;
               emit  = 1'b1;
            end
            3'b101: begin
               job.p = vs0;
               job.q = vs2;
               emit  = 1'b1;
            end
            3'b110: begin
               job.p = vs1;
               job.q = vs2;
               emit  = 1'b1;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   assign push = valid_ff && emit;

endmodule

@@ hdl/slc_queue.sv @@
// Two-entry queue between the classifier and the arithmetic back end.
module slc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  slc_pkg::job_type push_job,
   output logic             head_valid,
   output slc_pkg::job_type head_job,
   output logic             full
);

   slc_pkg::job_type mem_ff [0:1];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;
   logic             pop;

   // The back end never stalls, so the head leaves in the cycle it shows up.
   assign pop        = (count_ff != 2'd0);
   assign head_valid = pop;
   assign head_job   = mem_ff[rd_ptr_ff];
   assign full       = (count_ff == 2'd2);
   assign count_in   = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ hdl/slc_scale.sv @@
// Pipelined base + trunc(num * delta / denom) with a one-bit-per-stage divider.
module slc_scale (
   input  logic        clock,
   input  logic [32:0] num,
   input  logic [32:0] delta,
   input  logic [32:0] denom,
   input  logic [31:0] base,
   output logic [31:0] result
);

   localparam int N = slc_pkg::DIV_STEPS;

   logic [32:0] an, ad;
   logic        neg_in, neg_a_ff, neg_b_ff;
   logic [32:0] dm_in, dm_a_ff, dm_b_ff;
   logic [31:0] base_a_ff, base_b_ff;
   logic [63:0] pll_in, pll_ff;
   logic [32:0] mid_in, mid_ff;
   logic        hh_in, hh_ff;
   logic [65:0] prod_in, prod_ff;

   assign an     = slc_pkg::abs33(num);
   assign ad     = slc_pkg::abs33(delta);
   assign neg_in = num[32] ^ delta[32] ^ denom[32];
   assign dm_in  = slc_pkg::abs33(denom);
   assign pll_in = 64'(an[31:0]) * 64'(ad[31:0]);
   assign mid_in = 33'(an[32] ? ad[31:0] : 32'd0) + 33'(ad[32] ? an[31:0] : 32'd0);
   assign hh_in  = an[32] & ad[32];

   always_ff @(posedge clock) begin
      neg_a_ff  <= neg_in;
      dm_a_ff   <= dm_in;
      base_a_ff <= base;
      pll_ff    <= pll_in;
      mid_ff    <= mid_in;
      hh_ff     <= hh_in;
   end

   assign prod_in = 66'(pll_ff) + (66'(mid_ff) << 32) + (66'(hh_ff) << 64);

   always_ff @(posedge clock) begin
      neg_b_ff  <= neg_a_ff;
      dm_b_ff   <= dm_a_ff;
      base_b_ff <= base_a_ff;
      prod_ff   <= prod_in;
   end

   logic [32:0] rem_ff  [0:N-1];
   logic [32:0] lo_ff   [0:N-1];
   logic [32:0] q_ff    [0:N-1];
   logic [32:0] dm_ff   [0:N-1];
   logic        neg_ff  [0:N-1];
   logic [31:0] base_ff [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_div
      logic [32:0] rem_prev, lo_prev, q_prev, dm_prev;
      logic        neg_prev;
      logic [31:0] base_prev;
      logic [33:0] trial;
      logic        fit;
      logic [32:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_prev  = prod_ff[65:33];
         assign lo_prev   = prod_ff[32:0];
         assign q_prev    = '0;
         assign dm_prev   = dm_b_ff;
         assign neg_prev  = neg_b_ff;
         assign base_prev = base_b_ff;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign lo_prev   = lo_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign dm_prev   = dm_ff[k-1];
         assign neg_prev  = neg_ff[k-1];
         assign base_prev = base_ff[k-1];
      end

      assign trial  = {rem_prev, lo_prev[32]};
      assign fit    = trial >= {1'b0, dm_prev};
      assign rem_in = fit ? 33'(trial - {1'b0, dm_prev}) : trial[32:0];

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         lo_ff[k]   <= {lo_prev[31:0], 1'b0};
         q_ff[k]    <= {q_prev[31:0], fit};
         dm_ff[k]   <= dm_prev;
         neg_ff[k]  <= neg_prev;
         base_ff[k] <= base_prev;
      end
   end

   logic [32:0] sq;
   logic [31:0] result_in, result_ff;

   assign sq        = neg_ff[N-1] ? 33'(-q_ff[N-1]) : q_ff[N-1];
   assign result_in = base_ff[N-1] + sq[31:0];

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

@@ hdl/slc_back.sv @@
// Back end: interpolates both segment endpoints and aligns the side data.
module slc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  slc_pkg::job_type job,
   output logic             out_valid,
   output logic [31:0]      p_x,
   output logic [31:0]      p_y,
   output logic [31:0]      p_z,
   output logic [31:0]      q_x,
   output logic [31:0]      q_y,
   output logic [31:0]      q_z,
   output logic [11:0]      layer
);

   localparam int L = slc_pkg::SCALE_LAT;

   typedef struct packed {
      logic [11:0] layer;
      logic [31:0] p_y;
      logic [31:0] q_y;
   } side_type;

   logic     valid_ff [0:L-1];
   side_type side_ff  [0:L-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < L; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= job_valid;
         for (int k = 1; k < L; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= '{layer: job.layer, p_y: job.p.out_y, q_y: job.q.out_y};
      for (int k = 1; k < L; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   slc_scale u_px (.clock(clock), .num(job.p.n), .delta(job.p.dx), .denom(job.p.dy),
                   .base(job.p.base_x), .result(p_x));
   slc_scale u_pz (.clock(clock), .num(job.p.n), .delta(job.p.dz), .denom(job.p.dy),
                   .base(job.p.base_z), .result(p_z));
   slc_scale u_qx (.clock(clock), .num(job.q.n), .delta(job.q.dx), .denom(job.q.dy),
                   .base(job.q.base_x), .result(q_x));
   slc_scale u_qz (.clock(clock), .num(job.q.n), .delta(job.q.dz), .denom(job.q.dy),
                   .base(job.q.base_z), .result(q_z));

   assign out_valid = valid_ff[L-1];
   assign p_y       = side_ff[L-1].p_y;
   assign q_y       = side_ff[L-1].q_y;
   assign layer     = side_ff[L-1].layer;

endmodule

@@ tb/sv/triangle_layer_slice_segment_test.sv @@
// Self-checking testbench for the triangle slicer with a segment scoreboard.
module triangle_layer_slice_segment_test;

   // Watchdog limit, in cycles without any accepted triangle or segment.
   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = slc_pkg::SCALE_LAT + 16;

   typedef struct {
      longint x;
      longint y;
      longint z;
   } point_type;

   typedef struct packed {
      logic [31:0] p_x;
      logic [31:0] p_y;
      logic [31:0] p_z;
      logic [31:0] q_x;
      logic [31:0] q_y;
      logic [31:0] q_z;
      logic [11:0] layer;
   } segment_type;

   // The scoreboard predicts the segment of each accepted triangle and keeps
   // the expected segments in arrival order.
   class segment_scoreboard;
      segment_type pending_segments[$];
      int          failures;
      logic [15:0] threshold;

      function new();
         failures  = 0;
         threshold = slc_pkg::THRESHOLD_RESET;
      endfunction

      // Cuts edge (u, w) with the layer; the offset is exact and truncated
      // toward zero, which the signed division of SystemVerilog does.
      function automatic bit cut_edge(point_type u, point_type w, longint ly,
                                      output point_type p);
         logic signed [69:0] num;
         logic signed [69:0] den;
         logic signed [69:0] dx;
         logic signed [69:0] dz;
         p = '{0, 0, 0};
         if (u.x == w.x && u.y == w.y && u.z == w.z) return 0;
         if ((u.y > ly && w.y > ly) || (u.y < ly && w.y < ly)) return 0;
         if (u.y == w.y) return 0;
         num = ly - w.y;
         den = u.y - w.y;
         dx  = u.x - w.x;
         dz  = u.z - w.z;
         p.x = w.x + longint'((num * dx) / den);
         p.y = ly;
         p.z = w.z + longint'((num * dz) / den);
         return 1;
      endfunction

      function automatic void note_triangle(slc_pkg::tri_type t);
         point_type   v[3];
         point_type   cut[3];
         point_type   tmp;
         longint      ly;
         longint      gap;
         int          cuts;
         int          on_count;
         int          on_idx[3];
         segment_type seg;
         ly = longint'($signed(t.layer_y));
         for (int i = 0; i < 3; i++) begin
            v[i].x = longint'($signed(t.v[i].x));
            v[i].y = longint'($signed(t.v[i].y));
            v[i].z = longint'($signed(t.v[i].z));
         end
         if (int'(t.layer_index) >= 4096) return;
         if ((v[0].y > ly && v[1].y > ly && v[2].y > ly) ||
             (v[0].y < ly && v[1].y < ly && v[2].y < ly)) return;
         if (v[0].y != ly && v[1].y != ly && v[2].y != ly) begin
            cuts = 0;
            if (cut_edge(v[0], v[1], ly, tmp)) begin cut[cuts] = tmp; cuts++; end
            if (cut_edge(v[0], v[2], ly, tmp)) begin cut[cuts] = tmp; cuts++; end
            if (cut_edge(v[1], v[2], ly, tmp)) begin cut[cuts] = tmp; cuts++; end
            if (cuts != 2) return;
         end else begin
            on_count = 0;
            for (int i = 0; i < 3; i++) begin
               gap = v[i].y - ly;
               if (gap < 0) gap = -gap;
               if (gap < longint'(threshold)) begin
                  on_idx[on_count] = i;
                  on_count++;
               end
            end
            if (on_count == 1) begin
               cut[0] = v[on_idx[0]];
               // The edge opposite a vertex joins the other two in order.
               case (on_idx[0])
                  0: if (!cut_edge(v[1], v[2], ly, cut[1])) return;
                  1: if (!cut_edge(v[0], v[2], ly, cut[1])) return;
                  default: if (!cut_edge(v[0], v[1], ly, cut[1])) return;
               endcase
            end else if (on_count == 2) begin
               cut[0] = v[on_idx[0]];
               cut[1] = v[on_idx[1]];
            end else begin
               return;
            end
         end
         seg.p_x   = cut[0].x[31:0];
         seg.p_y   = cut[0].y[31:0];
         seg.p_z   = cut[0].z[31:0];
         seg.q_x   = cut[1].x[31:0];
         seg.q_y   = cut[1].y[31:0];
         seg.q_z   = cut[1].z[31:0];
         seg.layer = t.layer_index;
         pending_segments.insert(pending_segments.size(), seg);
      endfunction

      function automatic void check_segment(segment_type got);
         segment_type want;
         if (pending_segments.size() == 0) begin
            $error("segment with no triangle pending: %p", got);
            failures++;
            return;
         end
         want = pending_segments.pop_front();
         if (got.p_x !== want.p_x) begin
            $error("p_x expected %h actual %h", want.p_x, got.p_x); failures++;
         end
         if (got.p_y !== want.p_y) begin
            $error("p_y expected %h actual %h", want.p_y, got.p_y); failures++;
         end
         if (got.p_z !== want.p_z) begin
            $error("p_z expected %h actual %h", want.p_z, got.p_z); failures++;
         end
         if (got.q_x !== want.q_x) begin
            $error("q_x expected %h actual %h", want.q_x, got.q_x); failures++;
         end
         if (got.q_y !== want.q_y) begin
            $error("q_y expected %h actual %h", want.q_y, got.q_y); failures++;
         end
         if (got.q_z !== want.q_z) begin
            $error("q_z expected %h actual %h", want.q_z, got.q_z); failures++;
         end
         if (got.layer !== want.layer) begin
            $error("segment_layer expected %h actual %h", want.layer, got.layer);
            failures++;
         end
      endfunction

      function automatic int pending();
         return pending_segments.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [31:0] req_layer_y;
   logic [11:0] req_layer_index;
   logic [31:0] req_a_x, req_a_y, req_a_z;
   logic [31:0] req_b_x, req_b_y, req_b_z;
   logic [31:0] req_c_x, req_c_y, req_c_z;
   logic        rsp_valid;
   logic [31:0] rsp_p_x, rsp_p_y, rsp_p_z;
   logic [31:0] rsp_q_x, rsp_q_y, rsp_q_z;
   logic [11:0] rsp_segment_layer;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [slc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   segment_scoreboard slices;
   int idle_cycles;

   triangle_layer_slice_segment i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_layer_y      (req_layer_y),
      .req_layer_index  (req_layer_index),
      .req_a_x          (req_a_x),
      .req_a_y          (req_a_y),
      .req_a_z          (req_a_z),
      .req_b_x          (req_b_x),
      .req_b_y          (req_b_y),
      .req_b_z          (req_b_z),
      .req_c_x          (req_c_x),
      .req_c_y          (req_c_y),
      .req_c_z          (req_c_z),
      .rsp_valid        (rsp_valid),
      .rsp_p_x          (rsp_p_x),
      .rsp_p_y          (rsp_p_y),
      .rsp_p_z          (rsp_p_z),
      .rsp_q_x          (rsp_q_x),
      .rsp_q_y          (rsp_q_y),
      .rsp_q_z          (rsp_q_z),
      .rsp_segment_layer(rsp_segment_layer),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: at each rising edge an accepted triangle goes to the predictor
   // and a segment on the result ports is checked. The watchdog counts cycles
   // in which neither side moves a transaction.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy) begin
            slices.note_triangle('{req_layer_y, req_layer_index,
               {{req_c_x, req_c_y, req_c_z}, {req_b_x, req_b_y, req_b_z},
                {req_a_x, req_a_y, req_a_z}}});
         end
         if (rsp_valid) begin
            slices.check_segment('{rsp_p_x, rsp_p_y, rsp_p_z, rsp_q_x, rsp_q_y,
               rsp_q_z, rsp_segment_layer});
         end
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("triangle_layer_slice_segment verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Drives one triangle from the falling edge and holds it until accepted.
   // start stays high, so back-to-back triangles form a burst.
   task automatic send_triangle(slc_pkg::tri_type t);
      @(negedge clock);
      req_layer_y     = t.layer_y;
      req_layer_index = t.layer_index;
      {req_a_x, req_a_y, req_a_z} = t.v[0];
      {req_b_x, req_b_y, req_b_z} = t.v[1];
      {req_c_x, req_c_y, req_c_z} = t.v[2];
      start = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Waits until every expected segment has come out, then lets the pipeline
   // flush the triangles that give no segment.
   task automatic drain();
      pause_sender(0);
      while (slices.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [15:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_paddr   = slc_pkg::CSR_ADDR_W'(4 * slc_pkg::REG_THRESHOLD);
      csr_pwdata  = {16'h0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      slices.threshold = value;
   endtask

   // Picks a vertex height relative to the layer: exactly on it, within the
   // threshold on either side, near it, or anywhere.
   function automatic logic [31:0] pick_height(logic [31:0] ly);
      case ($urandom_range(0, 5))
         0: return ly;
         1: return ly + 32'($urandom_range(0, int'(slices.threshold)));
         2: return ly - 32'($urandom_range(0, int'(slices.threshold)));
         3: return ly + 32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'h0001_ffff);
         4: return ly + ($urandom() >> $urandom_range(1, 31));
         default: return $urandom();
      endcase
   endfunction

   function automatic slc_pkg::tri_type random_triangle();
      slc_pkg::tri_type t;
      t.layer_y     = ($urandom_range(0, 3) == 0) ? $urandom() :
                      32'($signed($urandom()) >>> $urandom_range(4, 12));
      t.layer_index = 12'($urandom());
      for (int i = 0; i < 3; i++) begin
         t.v[i].x = $urandom();
         t.v[i].y = ($urandom_range(0, 15) == 0) ? $urandom() : pick_height(t.layer_y);
         t.v[i].z = $urandom();
      end
      // Now and then repeat a vertex or an edge height to reach the
      // degenerate edges.
      case ($urandom_range(0, 11))
         0: t.v[1] = t.v[0];
         1: t.v[2].y = t.v[1].y;
         2: t.v[2] = t.v[0];
         default: ;
      endcase
      return t;
   endfunction

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && count > 0; i++) begin
            send_triangle(random_triangle());
            count--;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 12));
      end
   endtask

   function automatic slc_pkg::tri_type make_triangle(logic [31:0] ly, logic [11:0] idx,
                                                      logic [31:0] ay, logic [31:0] by,
                                                      logic [31:0] cy);
      slc_pkg::tri_type t;
      t.layer_y     = ly;
      t.layer_index = idx;
      t.v[0] = '{32'h0001_0000, ay, 32'hfff0_0000};
      t.v[1] = '{32'h7fff_ffff, by, 32'h0020_0000};
      t.v[2] = '{32'h8000_0000, cy, 32'h7fff_ffff};
      return t;
   endfunction

   initial begin
      slc_pkg::tri_type t;
      slices          = new();
      reset           = 1'b1;
      start           = 1'b0;
      req_layer_y     = '0;
      req_layer_index = '0;
      {req_a_x, req_a_y, req_a_z} = '0;
      {req_b_x, req_b_y, req_b_z} = '0;
      {req_c_x, req_c_y, req_c_z} = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed triangles under the reset threshold.
      send_triangle(make_triangle(32'h0, 12'd0, 32'h10, 32'h20, 32'h30));
      send_triangle(make_triangle(32'h0, 12'd1, -32'h10, -32'h20, -32'h30));
      send_triangle(make_triangle(32'h0, 12'hfff, 32'h0001_0000, -32'h0001_0000,
                                  32'h0002_0000));
      send_triangle(make_triangle(32'h8000_0000, 12'h555, 32'h7fff_ffff,
                                  32'h8000_0001, 32'h8000_0000));
      send_triangle(make_triangle(32'h7fff_ffff, 12'haaa, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h7fff_fffe));
      // One vertex on the layer, with and without a crossing opposite.
      send_triangle(make_triangle(32'h100, 12'd7, 32'h100, 32'h900, -32'h900));
      send_triangle(make_triangle(32'h100, 12'd8, 32'h900, 32'h100, 32'h900));
      send_triangle(make_triangle(32'h100, 12'd9, 32'h900, -32'h900, 32'h100));
      // Two vertices on the layer, one exact and one within the threshold.
      send_triangle(make_triangle(32'h100, 12'd10, 32'h100, 32'h120, 32'h900));
      send_triangle(make_triangle(32'h100, 12'd11, 32'h900, 32'hf0, 32'h100));
      // All three on the layer.
      send_triangle(make_triangle(32'h100, 12'd12, 32'h100, 32'h101, 32'hff));
      // A vertex on the layer, one just outside the threshold and one just inside it.
      send_triangle(make_triangle(32'h100, 12'd13, 32'h100, 32'h100 + 32'd66,
                                  32'h100 - 32'd65));
      // A horizontal edge straddling nothing and a repeated vertex.
      send_triangle(make_triangle(32'h0, 12'd14, 32'h50, -32'h50, -32'h50));
      t = make_triangle(32'h0, 12'd15, 32'h50, 32'h50, -32'h70);
      t.v[1] = t.v[0];
      send_triangle(t);
      drain();

      // Threshold zero: exact hits count for nothing.
      write_threshold(16'd0);
      send_triangle(make_triangle(32'h100, 12'd20, 32'h100, 32'h900, -32'h900));
      random_phase(300);
      drain();

      write_threshold(16'hffff);
      send_triangle(make_triangle(32'h0, 12'd21, 32'h0, 32'hfffe, -32'hfffe));
      random_phase(350);
      drain();

      write_threshold(16'($urandom()));
      random_phase(300);
      drain();

      write_threshold(16'd1);
      random_phase(250);
      drain();

      write_threshold(slc_pkg::THRESHOLD_RESET);
      random_phase(300);
      drain();

      if (slices.failures == 0) begin
         $display("triangle_layer_slice_segment verification clean");
      end else begin
         $display("triangle_layer_slice_segment verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/slc_pkg.sv
hdl/slc_front.sv
hdl/slc_queue.sv
hdl/slc_scale.sv
hdl/slc_back.sv
hdl/triangle_layer_slice_segment.sv
tb/sv/triangle_layer_slice_segment_test.sv
